>>> rtl/dvru_pkg.sv
// Shared types and constants for the distance-vector route update block.
`timescale 1ns / 1ps

package dvru_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned COST_W = 8;
  localparam int unsigned SLOT_W = 6;

  localparam logic OP_ADVERT  = 1'b0;
  localparam logic OP_INSTALL = 1'b1;

  localparam logic [COST_W-1:0] HOP_LIMIT_RST = 8'd16;

  // register word index on the APB port
  localparam logic REG_HOP_LIMIT = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] dest_addr;
    logic [COST_W-1:0] route_cost;
    logic [ADDR_W-1:0] sender_addr;
    logic [ADDR_W-1:0] arrival_if_addr;
  } in_item_t;

  typedef struct packed {
    logic              changed;
    logic              table_full;
    logic [COST_W-1:0] entry_cost;
    logic [ADDR_W-1:0] entry_next_hop;
    logic [SLOT_W-1:0] entry_slot;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] next_hop;
    logic [ADDR_W-1:0] iface;
  } route_ent_t;

endpackage

>>> rtl/distance_vector_route_update_top.sv
// Top level of the distance-vector route update block.
`timescale 1ns / 1ps

// Distance-vector route table update.
// Input channel (in_valid/in_stall/in_data): one transaction per route item,
// either an advertisement or a direct install. Output channel (out_valid/
// out_stall/out_data): exactly one result transaction per input item.
// APB port: one register, hop_limit, at byte address 0 (reset value 16).
// One item is processed at a time. The table is scanned through the single
// read port of the route memory, one slot per cycle, lowest slot first,
// stopping at the first destination match. An item that hits slot k reads
// slots 0 to k; a miss reads every filled slot. The next item can be taken
// in the cycle after the result is registered.
// Reset empties the table at once: valid slots always form a prefix (entries
// are never removed, inserts take the lowest free slot), so a fill count
// marks them and no clearing pass is needed.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the next item finishes its scan and holds
// in the write-back step until the output register frees up.

module distance_vector_route_update_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dvru_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dvru_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  // control state
  logic [1:0]               state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            scan_r, scan_nxt;
  logic                     pend_r, pend_nxt;
  logic                     hit_r, hit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [dvru_pkg::COST_W-1:0] hop_r;

  // payload
  dvru_pkg::in_item_t       item_r;
  logic [IW-1:0]            pend_idx_r;
  logic [IW-1:0]            hit_idx_r;
  dvru_pkg::route_ent_t     hit_ent_r;
  dvru_pkg::out_item_t      out_r, out_nxt;

  // memory ports
  logic                     mem_we, mem_re;
  logic [IW-1:0]            mem_waddr;
  dvru_pkg::route_ent_t     mem_wdata, mem_rdata;

  logic                     in_acc, cfg_wr, out_free, hit_now, upd_go;

  dvru_table_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign upd_go    = (state_r == ST_UPD) && out_free;

  // APB: single register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dvru_pkg::REG_HOP_LIMIT);
  assign prdata = (paddr[2] == dvru_pkg::REG_HOP_LIMIT) ? {24'd0, hop_r} : 32'd0;

  // match on the slot read in the previous cycle
  assign hit_now = (state_r == ST_SCAN) && pend_r &&
                   (mem_rdata.dest == item_r.dest_addr);

  // scan sequencer
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    pend_nxt  = 1'b0;
    hit_nxt   = hit_r;
    mem_re    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          scan_nxt  = '0;
          hit_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_UPD;
        end else if (scan_r != fill_r) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          scan_nxt = scan_r + CW'(1);
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // route decision and write-back
  logic [8:0]                  c1, hop9, stored9;
  logic [dvru_pkg::COST_W-1:0] sat_c1, sat_cost;
  logic [IW-1:0]               slot;
  dvru_pkg::route_ent_t        new_ent;
  logic                        full, changed;

  always_comb begin
    c1       = {1'b0, item_r.route_cost} + 9'd1;
    hop9     = {1'b0, hop_r};
    stored9  = {1'b0, hit_ent_r.cost};
    sat_c1   = (c1 < hop9) ? c1[7:0] : hop_r;
    sat_cost = (item_r.route_cost < hop_r) ? item_r.route_cost : hop_r;
    full     = 1'b0;
    changed  = 1'b0;
    slot     = hit_idx_r;
    new_ent  = hit_ent_r;
    fill_nxt = fill_r;

    if (!hit_r) begin
      slot = fill_r[IW-1:0];
      if (fill_r == FULL_CNT) begin
        full = 1'b1;
      end else begin
        new_ent.dest     = item_r.dest_addr;
        new_ent.cost     = (item_r.opcode == dvru_pkg::OP_INSTALL) ? sat_cost : sat_c1;
        new_ent.next_hop = item_r.sender_addr;
        new_ent.iface    = item_r.arrival_if_addr;
        changed          = 1'b1;
        fill_nxt         = fill_r + CW'(1);
      end
    end else if (item_r.opcode == dvru_pkg::OP_INSTALL) begin
      new_ent.cost     = sat_cost;
      new_ent.next_hop = item_r.sender_addr;
      new_ent.iface    = item_r.arrival_if_addr;
      changed          = 1'b1;
    end else if (stored9 > c1) begin
      // better route: take it over, unless it would reach the limit
      if (c1 >= hop9) begin
        new_ent.cost = hop_r;
      end else begin
        new_ent.cost     = c1[7:0];
        new_ent.next_hop = item_r.sender_addr;
        new_ent.iface    = item_r.arrival_if_addr;
        changed          = 1'b1;
      end
    end else if (stored9 < c1 && item_r.sender_addr == hit_ent_r.next_hop) begin
      // current next hop reports worse cost
      if (c1 >= hop9) begin
        new_ent.cost = hop_r;
      end else begin
        new_ent.cost = c1[7:0];
        changed      = 1'b1;
      end
    end

    if (!upd_go) begin
      fill_nxt = fill_r;
    end

    mem_we    = upd_go && !full;
    mem_waddr = slot;
    mem_wdata = new_ent;

    out_nxt.changed        = changed;
    out_nxt.table_full     = full;
    out_nxt.entry_cost     = full ? '0 : new_ent.cost;
    out_nxt.entry_next_hop = full ? '0 : new_ent.next_hop;
    out_nxt.entry_slot     = full ? '0 : dvru_pkg::SLOT_W'(slot);

    out_valid_nxt = out_valid_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hop_r       <= dvru_pkg::HOP_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        hop_r <= pwdata[7:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (mem_re) begin
      pend_idx_r <= scan_r[IW-1:0];
    end
    if (hit_now) begin
      hit_idx_r <= pend_idx_r;
      hit_ent_r <= mem_rdata;
    end
    if (upd_go) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/dvru_table_mem.sv
// Route table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module dvru_table_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  dvru_pkg::route_ent_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output dvru_pkg::route_ent_t rdata
);

  dvru_pkg::route_ent_t mem [DEPTH];
  dvru_pkg::route_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> dv/route_table_checker.sv
// Route table checker: predicts each route result and compares it with the block's output.
`timescale 1ns / 1ps

module route_table_checker
  import dvru_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);

  localparam logic [2:0] HOP_LIMIT_ADDR = {REG_HOP_LIMIT, 2'b00};

  logic              slot_used [TABLE_ENTRIES];
  route_ent_t        routes    [TABLE_ENTRIES];
  logic [COST_W-1:0] hop_limit_q;
  out_item_t         owed_results [$];

  initial mismatch_count = 0;
  initial results_owed   = 0;

  // costs saturate at the hop limit; 9 bits so cost+1 never wraps
  function automatic logic [COST_W-1:0] clamp_cost(input logic [COST_W:0] c);
    return (c < {1'b0, hop_limit_q}) ? c[COST_W-1:0] : hop_limit_q;
  endfunction

  function automatic out_item_t apply_route(input in_item_t item);
    logic [COST_W:0] hop_cost;
    logic [COST_W:0] stored;
    int              hit;
    int              free_slot;
    out_item_t       res;
    hop_cost  = {1'b0, item.route_cost} + 9'd1;
    hit       = -1;
    free_slot = -1;
    res       = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && routes[i].dest == item.dest_addr) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        res.table_full = 1'b1;
        return res;
      end
      hit                 = free_slot;
      slot_used[hit]      = 1'b1;
      routes[hit].dest    = item.dest_addr;
      routes[hit].cost    = clamp_cost((item.opcode == OP_INSTALL) ?
                                       {1'b0, item.route_cost} : hop_cost);
      routes[hit].next_hop = item.sender_addr;
      routes[hit].iface   = item.arrival_if_addr;
      res.changed         = 1'b1;
    end else if (item.opcode == OP_INSTALL) begin
      routes[hit].cost     = clamp_cost({1'b0, item.route_cost});
      routes[hit].next_hop = item.sender_addr;
      routes[hit].iface    = item.arrival_if_addr;
      res.changed          = 1'b1;
    end else begin
      stored = {1'b0, routes[hit].cost};
      if (stored > hop_cost) begin
        // cheaper path; poisoned silently if it still reaches the limit
        if (hop_cost >= {1'b0, hop_limit_q}) begin
          routes[hit].cost = hop_limit_q;
        end else begin
          routes[hit].cost     = hop_cost[COST_W-1:0];
          routes[hit].next_hop = item.sender_addr;
          routes[hit].iface    = item.arrival_if_addr;
          res.changed          = 1'b1;
        end
      end else if (stored < hop_cost && item.sender_addr == routes[hit].next_hop) begin
        if (hop_cost >= {1'b0, hop_limit_q}) begin
          routes[hit].cost = hop_limit_q;
        end else begin
          routes[hit].cost = hop_cost[COST_W-1:0];
          res.changed      = 1'b1;
        end
      end
    end
    res.entry_cost     = routes[hit].cost;
    res.entry_next_hop = routes[hit].next_hop;
    res.entry_slot     = SLOT_W'(hit);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 200)
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        routes[i]    = '0;
      end
      hop_limit_q = HOP_LIMIT_RST;
      owed_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == HOP_LIMIT_ADDR)
        hop_limit_q = pwdata[COST_W-1:0];
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unrequested result", 32'(out_data.entry_slot), 32'hX);
        end else begin
          want = owed_results.pop_front();
          if (out_data.changed !== want.changed)
            report_mismatch("changed", 32'(out_data.changed), 32'(want.changed));
          if (out_data.table_full !== want.table_full)
            report_mismatch("table_full", 32'(out_data.table_full), 32'(want.table_full));
          if (out_data.entry_cost !== want.entry_cost)
            report_mismatch("entry_cost", 32'(out_data.entry_cost), 32'(want.entry_cost));
          if (out_data.entry_next_hop !== want.entry_next_hop)
            report_mismatch("entry_next_hop", out_data.entry_next_hop, want.entry_next_hop);
          if (out_data.entry_slot !== want.entry_slot)
            report_mismatch("entry_slot", 32'(out_data.entry_slot), 32'(want.entry_slot));
        end
      end
      if (in_valid && !in_stall)
        owed_results.insert(owed_results.size(), apply_route(in_data));
    end
    results_owed <= owed_results.size();
  end

endmodule

>>> dv/distance_vector_route_update_top_tb.sv
// Testbench top: stimulus, idling and verdict for the route update block.
`timescale 1ns / 1ps

module distance_vector_route_update_top_tb;
  import dvru_pkg::*;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned DEST_POOL   = 56;
  // longest quiet stretch of a sound run is a full table scan plus a
  // long run of receiver stalls; this is many times that
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam logic [2:0]  HOP_LIMIT_ADDR = {REG_HOP_LIMIT, 2'b00};

  // a few fixed addresses for the directed transactions
  localparam logic [31:0] DST_A = 32'h0A01_0000;
  localparam logic [31:0] DST_B = 32'h0A02_0000;
  localparam logic [31:0] DST_C = 32'hC0A8_0100;
  localparam logic [31:0] NBR_1 = 32'h0A00_0001;
  localparam logic [31:0] NBR_2 = 32'h0A00_0002;
  localparam logic [31:0] NBR_3 = 32'h0A00_0003;
  localparam logic [31:0] IF_0  = 32'hAC10_0001;
  localparam logic [31:0] IF_1  = 32'hAC10_0101;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatch_count;
  int unsigned results_owed;

  // idling percentages for the current phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;

  // stimulus pools: a small set of destinations so that most adverts hit
  // the table, a handful of neighbours so that next-hop matches are common
  logic [31:0]       dest_pool [DEST_POOL];
  logic [31:0]       nbr_pool  [4];
  logic [31:0]       if_pool   [2];
  logic [COST_W-1:0] cur_limit = HOP_LIMIT_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  distance_vector_route_update_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  route_table_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Receiver side: a fresh stall decision every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic in_item_t route_item(input logic op, input logic [31:0] dest,
                                          input logic [7:0] cost, input logic [31:0] from,
                                          input logic [31:0] ifa);
    in_item_t it;
    it.opcode          = op;
    it.dest_addr       = dest;
    it.route_cost      = cost;
    it.sender_addr     = from;
    it.arrival_if_addr = ifa;
    return it;
  endfunction

  // Random route transaction. Mostly adverts on known destinations with
  // costs around the hop limit; some noise on every field.
  function automatic in_item_t make_route_item();
    in_item_t    it;
    int unsigned hi;
    it.opcode    = ($urandom_range(99) < 15) ? OP_INSTALL : OP_ADVERT;
    it.dest_addr = ($urandom_range(99) < 6) ? $urandom() :
                   dest_pool[$urandom_range(DEST_POOL - 1)];
    hi = int'(cur_limit) + 2;
    if (hi > 255) hi = 255;
    it.route_cost  = ($urandom_range(99) < 15) ? 8'($urandom_range(255)) :
                     8'($urandom_range(hi));
    it.sender_addr = ($urandom_range(99) < 10) ? $urandom() : nbr_pool[$urandom_range(3)];
    it.arrival_if_addr = ($urandom_range(99) < 20) ? $urandom() : if_pool[$urandom_range(1)];
    return it;
  endfunction

  // Present one transaction, after a random gap; valid stays high on return
  // so that back-to-back transactions need no second assignment.
  task automatic send_item(input in_item_t item);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // stall is settled by the falling edge; it decides the coming edge
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_hop_limit(input logic [COST_W-1:0] lim);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HOP_LIMIT_ADDR;
    pwdata  <= {24'($urandom()), lim};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    cur_limit = lim;
  endtask

  initial begin
    logic [COST_W-1:0] lim;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    for (int i = 0; i < DEST_POOL; i++) dest_pool[i] = $urandom();
    for (int i = 0; i < 4; i++) nbr_pool[i] = $urandom();
    if_pool[0] = $urandom();
    if_pool[1] = $urandom();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, hop limit at its reset value of 16.
    send_item(route_item(OP_ADVERT,   DST_A, 8'd0,   NBR_1, IF_0));  // insert, cost 1
    send_item(route_item(OP_ADVERT,   DST_A, 8'd0,   NBR_2, IF_1));  // equal cost, no change
    send_item(route_item(OP_ADVERT,   DST_A, 8'd5,   NBR_2, IF_1));  // worse, other neighbour
    send_item(route_item(OP_ADVERT,   DST_A, 8'd5,   NBR_1, IF_0));  // worse from next hop: raise
    send_item(route_item(OP_ADVERT,   DST_A, 8'd2,   NBR_2, IF_1));  // cheaper: take over
    send_item(route_item(OP_ADVERT,   DST_A, 8'd15,  NBR_2, IF_1));  // raise hits limit: poison
    send_item(route_item(OP_ADVERT,   DST_A, 8'd255, NBR_2, IF_1));  // cost+1 past 8 bits
    send_item(route_item(OP_ADVERT,   DST_A, 8'd20,  NBR_1, IF_0));  // worse, not next hop
    send_item(route_item(OP_INSTALL,  DST_A, 8'd255, NBR_3, IF_0));  // install, saturated
    send_item(route_item(OP_INSTALL,  DST_B, 8'd0,   NBR_3, IF_1));  // install new, cost 0
    send_item(route_item(OP_ADVERT,   DST_B, 8'd254, NBR_1, IF_0));  // far worse, ignored
    send_item(route_item(OP_ADVERT,   DST_C, 8'd255, NBR_2, IF_1));  // insert saturated
    send_item(route_item(OP_ADVERT,   DST_A, 8'd14,  NBR_1, IF_0));  // take over from poisoned
    send_item(route_item(OP_ADVERT,   DST_C, 8'd15,  NBR_1, IF_0));  // equal cost at limit, no change
    send_item(route_item(OP_ADVERT,   32'h0, 8'd0,   32'h0, 32'h0));
    send_item(route_item(OP_ADVERT,   '1,    8'd255, '1,    '1));
    send_item(route_item(OP_INSTALL,  '1,    8'd3,   32'h0, '1));    // overwrite existing
    in_valid <= 1'b0;
    wait_drained();

    // Random phases: each with its own hop limit and idling pattern.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 78;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 78;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct     = 16;
        end
      endcase
      case (ph)
        0, 7:    lim = 8'd255;
        1:       lim = 8'd1;
        2:       lim = 8'd0;   // zero limit: every cost saturates to 0
        3:       lim = HOP_LIMIT_RST;
        6:       lim = 8'd3;
        default: lim = 8'($urandom_range(254, 2));
      endcase
      write_hop_limit(lim);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(make_route_item());
      in_valid <= 1'b0;
      wait_drained();
    end

    // catch any stray result after the last one owed
    stall_pct = 0;
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dvru_pkg.sv
rtl/dvru_table_mem.sv
rtl/distance_vector_route_update_top.sv
dv/route_table_checker.sv
dv/distance_vector_route_update_top_tb.sv
